// File: src/cdq_pkg.sv
// Package for the circular deque: sizes, request and status codes, the
// sequencer state type and the ring store access struct.
// No dependencies; every other file of the block imports it.
`default_nettype none

package cdq_pkg;

  // Built ring depth and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5,
    MODE_SEARCH     = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  // One write port and one read port of the ring store.
  typedef struct packed {
    logic  we;
    slot_t waddr;
    word_t wdata;
    slot_t raddr;
  } store_req_t;

endpackage

`default_nettype wire

// File: src/circular_deque.sv
// Circular deque of signed 32-bit words in a 16-entry ring store.
// Push, clear and the full and empty errors answer straight from the idle state;
// pop and peek go through one registered store read; search steps a cursor from
// the front to the match or the last held word, one held word compared per
// cycle through the single store read port. busy holds off the next word
// until the result shows; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the queue and sets capacity 16.
`default_nettype none

module circular_deque
  import cdq_pkg::*;
(
  input  var logic              clk_i,
  input  var logic              rst_ni,
  // Request channel.
  input  var logic              start,
  output logic                  busy,
  input  var logic [MODE_W-1:0] mode_i,
  input  var word_t             value_i,
  // Capacity register.
  input  var logic              cfg_we_i,
  input  var logic [CNT_W-1:0]  cfg_wdata_i,
  // Result channel, valid for the single cycle in which done_o is high.
  output logic                  done_o,
  output logic [STAT_W-1:0]     status_o,
  output word_t                 data_out_o,
  output logic [SLOT_W-1:0]     slot_index_o,
  output logic [SLOT_W-1:0]     position_o,
  output logic [CNT_W-1:0]      count_o,
  output logic                  is_empty_o,
  output logic                  is_full_o
);

  // Sequencer and queue state.
  state_e  state_q, state_d;
  cnt_t    cap_q, cap_d;
  slot_t   head_q, head_d;
  slot_t   tail_q, tail_d;
  cnt_t    count_q, count_d;

  // The request being worked on, and the search cursor.
  word_t   value_q, value_d;
  slot_t   scan_slot_q, scan_slot_d;
  slot_t   scan_pos_q, scan_pos_d;

  // Result registers.
  logic    done_q, done_d;
  status_e status_q, status_d;
  word_t   data_q, data_d;
  slot_t   slot_q, slot_d;
  slot_t   pos_q, pos_d;

  mode_e      mode;
  store_req_t store_req;
  word_t      rd_word;
  slot_t      head_next, head_prev;
  slot_t      tail_next, tail_prev;
  slot_t      scan_next, scan_prev;
  logic       q_empty, q_full;
  logic       accept;

  assign mode    = mode_e'(mode_i);
  assign q_empty = (count_q == '0);
  assign q_full  = (count_q >= cap_q);
  assign accept  = start && !busy;

  // Slot arithmetic for both ends of the ring and for the search cursor.
  cdq_ring_step u_head_step (
    .slot_i (head_q),
    .cap_i  (cap_q),
    .next_o (head_next),
    .prev_o (head_prev)
  );

  cdq_ring_step u_tail_step (
    .slot_i (tail_q),
    .cap_i  (cap_q),
    .next_o (tail_next),
    .prev_o (tail_prev)
  );

  // The cursor only ever moves forward; its previous slot goes unused in
  // the data path but is checked below against the slot the cursor left.
  cdq_ring_step u_scan_step (
    .slot_i (scan_slot_q),
    .cap_i  (cap_q),
    .next_o (scan_next),
    .prev_o (scan_prev)
  );

  cdq_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (rd_word)
  );

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    value_d     = value_q;
    scan_slot_d = scan_slot_q;
    scan_pos_d  = scan_pos_q;

    done_d   = 1'b0;
    status_d = STAT_OK;
    data_d   = '0;
    slot_d   = '0;
    pos_d    = '0;

    store_req.we    = 1'b0;
    store_req.waddr = tail_q;
    store_req.wdata = value_i;
    store_req.raddr = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d = value_i;
          case (mode)
            MODE_PUSH_FRONT: begin
              done_d = 1'b1;
              if (q_full) begin
                status_d = STAT_FULL;
              end else begin
                store_req.we    = 1'b1;
                store_req.waddr = head_prev;
                head_d          = head_prev;
                count_d         = count_q + CNT_W'(1);
              end
            end
            MODE_PUSH_BACK: begin
              done_d = 1'b1;
              if (q_full) begin
                status_d = STAT_FULL;
              end else begin
                store_req.we    = 1'b1;
                store_req.waddr = tail_q;
                tail_d          = tail_next;
                count_d         = count_q + CNT_W'(1);
              end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
              if (q_empty) begin
                done_d   = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                // The front word comes out of the store next cycle.
                store_req.raddr = head_q;
                state_d         = ST_READ;
                if (mode == MODE_POP_FRONT) begin
                  head_d  = head_next;
                  count_d = count_q - CNT_W'(1);
                end
              end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
              if (q_empty) begin
                done_d   = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                store_req.raddr = tail_prev;
                state_d         = ST_READ;
                if (mode == MODE_POP_BACK) begin
                  tail_d  = tail_prev;
                  count_d = count_q - CNT_W'(1);
                end
              end
            end
            MODE_SEARCH: begin
              if (q_empty) begin
                done_d   = 1'b1;
                status_d = STAT_NOT_FOUND;
              end else begin
                // Start the cursor at the front and fetch the first word.
                store_req.raddr = head_q;
                scan_slot_d     = head_q;
                scan_pos_d      = '0;
                state_d         = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              done_d  = 1'b1;
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        done_d  = 1'b1;
        data_d  = rd_word;
        state_d = ST_IDLE;
      end

      ST_SCAN: begin
        // The word at the cursor arrived from the store this cycle.
        if (rd_word == value_q) begin
          done_d  = 1'b1;
          slot_d  = scan_slot_q;
          pos_d   = scan_pos_q;
          state_d = ST_IDLE;
        end else if (CNT_W'(scan_pos_q) + CNT_W'(1) == count_q) begin
          done_d   = 1'b1;
          status_d = STAT_NOT_FOUND;
          state_d  = ST_IDLE;
        end else begin
          store_req.raddr = scan_next;
          scan_slot_d     = scan_next;
          scan_pos_d      = scan_pos_q + SLOT_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A capacity write clamps the value into range and empties the queue.
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        cap_d = CNT_W'(1);
      end else if (cfg_wdata_i > CNT_W'(DEPTH)) begin
        cap_d = CNT_W'(DEPTH);
      end else begin
        cap_d = cfg_wdata_i;
      end
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CNT_W'(DEPTH);
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q     <= value_d;
    scan_slot_q <= scan_slot_d;
    scan_pos_q  <= scan_pos_d;
    status_q    <= status_d;
    data_q      <= data_d;
    slot_q      <= slot_d;
    pos_q       <= pos_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign data_out_o   = data_q;
  assign slot_index_o = slot_q;
  assign position_o   = pos_q;
  // The count only changes on a request or a capacity write, so it still
  // reflects the request whose result is on the ports in the strobe cycle.
  assign count_o      = count_q;
  assign is_empty_o   = q_empty;
  assign is_full_o    = (count_q == cap_q);

  // The queue never holds more words than the capacity allows.
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("held count exceeds capacity");

  // Both ends of the ring stay inside the slots in use.
  a_ends_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((head_q < SLOT_W'(cap_q)) && (tail_q < SLOT_W'(cap_q))) || (cap_q == CNT_W'(DEPTH)))
    else $error("ring end outside capacity");

  // A store read always completes in the following cycle.
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (done_q && (state_q == ST_IDLE)))
    else $error("pop or peek result missing");

  // A pop on an empty queue answers at once with an error.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_we_i && (mode_i == MODE_POP_FRONT) && (count_q == '0))
    |=> (done_q && (status_q == STAT_EMPTY)))
    else $error("pop on empty queue not reported");

  // While scanning, stepping the cursor back lands on the slot it left.
  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && $past(state_q == ST_SCAN) && (scan_pos_q != $past(scan_pos_q)))
    |-> (scan_prev == $past(scan_slot_q)))
    else $error("search cursor stepped wrongly");

endmodule

`default_nettype wire

// File: src/cdq_ring_step.sv
// Ring slot stepper: next and previous slot, wrapping at the capacity.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ring_step
  import cdq_pkg::*;
(
  input  var slot_t slot_i,
  input  var cnt_t  cap_i,
  output slot_t     next_o,
  output slot_t     prev_o
);

  cnt_t slot_inc;

  assign slot_inc = CNT_W'(slot_i) + CNT_W'(1);
  assign next_o   = (slot_inc >= cap_i) ? '0 : SLOT_W'(slot_inc);
  assign prev_o   = (slot_i == '0) ? SLOT_W'(cap_i - CNT_W'(1)) : slot_i - SLOT_W'(1);

endmodule

`default_nettype wire

// File: src/cdq_store.sv
// Ring store of the deque: one write port, one read port with registered
// read data. Depends on cdq_pkg.
`default_nettype none

module cdq_store
  import cdq_pkg::*;
(
  input  var logic       clk_i,
  input  var store_req_t req_i,
  output word_t          rdata_o
);

  word_t mem [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: dv/circular_deque_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the circular deque: keeps its own ring, head, tail and count,
// predicts one result word per accepted request and checks the done_o words in order.
// Depends on cdq_pkg for the widths and the mode and status codes.
module circular_deque_checker
  import cdq_pkg::*;
(
  input  var logic              clk_i,
  input  var logic              rst_ni,
  input  var logic              start_i,
  input  var logic              busy_i,
  input  var logic [MODE_W-1:0] mode_i,
  input  var word_t             value_i,
  input  var logic              cfg_we_i,
  input  var logic [CNT_W-1:0]  cfg_wdata_i,
  input  var logic              done_i,
  input  var logic [STAT_W-1:0] status_i,
  input  var word_t             data_out_i,
  input  var logic [SLOT_W-1:0] slot_index_i,
  input  var logic [SLOT_W-1:0] position_i,
  input  var logic [CNT_W-1:0]  count_i,
  input  var logic              is_empty_i,
  input  var logic              is_full_i,
  output int                    mismatches_o,
  output int                    pending_o
);

  typedef struct packed {
    status_e status;
    word_t   data;
    slot_t   slot;
    slot_t   pos;
    cnt_t    count;
    logic    empty;
    logic    full;
  } deque_result_t;

  word_t         ring [DEPTH];
  slot_t         head;
  slot_t         tail;
  cnt_t          held;
  cnt_t          cap;
  deque_result_t expected_results [$];
  int            mismatches = 0;
  int            result_no = 0;

  assign mismatches_o = mismatches;

  // Walks the mirrored deque through one request and queues the result it must give.
  task automatic predict_deque_result(input mode_e m, input word_t v);
    deque_result_t r;
    slot_t         s;
    cnt_t          walk;
    cnt_t          idx;
    r = '0;
    r.status = STAT_OK;
    case (m)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (held >= cap) begin
          r.status = STAT_FULL;
        end else if (m == MODE_PUSH_FRONT) begin
          head = (head == '0) ? slot_t'(cap - 1'b1) : head - 1'b1;
          ring[head] = v;
          held = held + 1'b1;
        end else begin
          ring[tail] = v;
          tail = (cnt_t'(tail) + 1'b1 >= cap) ? '0 : tail + 1'b1;
          held = held + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_PEEK_FRONT: begin
        if (held == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data = ring[head];
          if (m == MODE_POP_FRONT) begin
            head = (cnt_t'(head) + 1'b1 >= cap) ? '0 : head + 1'b1;
            held = held - 1'b1;
          end
        end
      end
      MODE_POP_BACK, MODE_PEEK_BACK: begin
        if (held == '0) begin
          r.status = STAT_EMPTY;
        end else begin
          s = (tail == '0) ? slot_t'(cap - 1'b1) : tail - 1'b1;
          r.data = ring[s];
          if (m == MODE_POP_BACK) begin
            tail = s;
            held = held - 1'b1;
          end
        end
      end
      MODE_SEARCH: begin
        r.status = STAT_NOT_FOUND;
        for (walk = '0; walk < held; walk = walk + 1'b1) begin
          idx = cnt_t'(head) + walk;
          if (idx >= cap) idx = idx - cap;
          if (ring[idx[SLOT_W-1:0]] == v) begin
            r.status = STAT_OK;
            r.slot   = idx[SLOT_W-1:0];
            r.pos    = walk[SLOT_W-1:0];
            break;
          end
        end
      end
      default: begin
        head = '0;
        tail = '0;
        held = '0;
      end
    endcase
    r.count = held;
    r.empty = (held == '0);
    r.full  = (held == cap);
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t seen;
    deque_result_t want;
    if (!rst_ni) begin
      foreach (ring[i]) ring[i] = '0;
      head = '0;
      tail = '0;
      held = '0;
      cap  = cnt_t'(DEPTH);
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        seen.status = status_e'(status_i);
        seen.data   = data_out_i;
        seen.slot   = slot_index_i;
        seen.pos    = position_i;
        seen.count  = count_i;
        seen.empty  = is_empty_i;
        seen.full   = is_full_i;
        result_no++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result word %0d at %0t arrived with nothing expected",
                     result_no, $time);
        end else begin
          want = expected_results.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result word %0d at %0t mismatch", result_no, $time);
              $display("  expected status %0d data 0x%08h slot %0d pos %0d count %0d e%0b f%0b",
                       want.status, want.data, want.slot, want.pos, want.count,
                       want.empty, want.full);
              $display("  actual   status %0d data 0x%08h slot %0d pos %0d count %0d e%0b f%0b",
                       seen.status, seen.data, seen.slot, seen.pos, seen.count,
                       seen.empty, seen.full);
            end
          end
        end
      end
      // Capacity writes clamp to 1..DEPTH and empty the queue.
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) cap = cnt_t'(1);
        else if (cfg_wdata_i > cnt_t'(DEPTH)) cap = cnt_t'(DEPTH);
        else cap = cfg_wdata_i;
        head = '0;
        tail = '0;
        held = '0;
      end
      if (start_i && !busy_i) predict_deque_result(mode_e'(mode_i), value_i);
      pending_o <= expected_results.size();
    end
  end

endmodule

// File: dv/circular_deque_tb.sv
`timescale 1ns / 1ps
// Top of the circular deque testbench: clock, reset, request stimulus and the verdict.
// Depends on cdq_pkg, the circular_deque block and circular_deque_checker.
module circular_deque_tb;
  import cdq_pkg::*;

  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 160;
  // The limit covers the worst run: a full-depth search for every word and
  // the longest sender gap after each.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 24;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [MODE_W-1:0] mode_i = '0;
  word_t             value_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  word_t             data_out_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic [SLOT_W-1:0] position_o;
  logic [CNT_W-1:0]  count_o;
  logic              is_empty_o;
  logic              is_full_o;

  int    mismatch_count;
  int    words_in_flight;
  int    cycle_count = 0;
  // Per-phase knobs of the random part: push share, idling on or off and the
  // small set of values that pushes and searches share so searches hit.
  int    push_pct = 50;
  bit    gaps_on = 1'b1;
  word_t value_pool [8];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  circular_deque dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .slot_index_o (slot_index_o),
    .position_o   (position_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  circular_deque_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .data_out_i   (data_out_o),
    .slot_index_i (slot_index_o),
    .position_i   (position_o),
    .count_i      (count_o),
    .is_empty_i   (is_empty_o),
    .is_full_i    (is_full_o),
    .mismatches_o (mismatch_count),
    .pending_o    (words_in_flight)
  );

  // Watchdog: a hung handshake or a lost result word ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called right after a rising edge. Raises start with the request word and
  // holds it until an edge with busy low takes it. The busy read right after
  // the edge still holds the value the block saw at that edge. With a gap of
  // zero start simply stays high for the next word.
  task automatic issue_request(input mode_e m, input word_t v);
    int gap;
    start   <= 1'b1;
    mode_i  <= m;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start   <= 1'b0;
      mode_i  <= MODE_W'($urandom);
      value_i <= word_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drops start and waits until every expected result word has come and the
  // block is idle again. Every request gives one result, so a short pause is enough.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (words_in_flight != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  // The capacity register is only written with the queue idle.
  task automatic write_capacity(input logic [CNT_W-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= CNT_W'($urandom);
  endtask

  // Random request word: pushes and pops balanced by push_pct so the queue
  // swings between empty and full, with searches, peeks and rare clears.
  task automatic random_request();
    int    pick;
    mode_e m;
    word_t v;
    pick = $urandom_range(0, 99);
    if (pick < 2) m = MODE_CLEAR;
    else if (pick < 12) m = MODE_SEARCH;
    else if (pick < 22) m = $urandom_range(0, 1) ? MODE_PEEK_FRONT : MODE_PEEK_BACK;
    else if ($urandom_range(0, 99) < push_pct)
      m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
    else m = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
    if ($urandom_range(0, 9) < 6) v = value_pool[$urandom_range(0, 7)];
    else v = word_t'($urandom);
    issue_request(m, v);
  endtask

  initial begin
    logic [CNT_W-1:0] cap_value;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity of 16. Every pop, peek and search
    // first meets an empty queue, then the word extremes go in at both ends;
    // the first push at the front wraps the head to the top slot.
    issue_request(MODE_POP_FRONT, '0);
    issue_request(MODE_POP_BACK, '0);
    issue_request(MODE_PEEK_FRONT, '0);
    issue_request(MODE_PEEK_BACK, '0);
    issue_request(MODE_SEARCH, '0);
    issue_request(MODE_PUSH_FRONT, 32'sh8000_0000);
    issue_request(MODE_PUSH_BACK, 32'sh7FFF_FFFF);
    issue_request(MODE_PUSH_FRONT, 32'sh0000_0000);
    issue_request(MODE_PUSH_BACK, 32'shFFFF_FFFF);
    issue_request(MODE_PEEK_FRONT, '0);
    issue_request(MODE_PEEK_BACK, '0);
    issue_request(MODE_SEARCH, 32'sh7FFF_FFFF);
    issue_request(MODE_SEARCH, 32'sh1234_5678);
    issue_request(MODE_POP_FRONT, '0);
    issue_request(MODE_POP_BACK, '0);
    // Clear keeps the stored words but they are no longer held.
    issue_request(MODE_CLEAR, '0);
    issue_request(MODE_PEEK_FRONT, '0);

    // A capacity of zero acts as one: the second push must report full.
    write_capacity('0);
    issue_request(MODE_PUSH_BACK, 32'sh5A5A_5A5A);
    issue_request(MODE_PUSH_FRONT, 32'sh0F0F_0F0F);
    issue_request(MODE_SEARCH, 32'sh5A5A_5A5A);
    issue_request(MODE_PEEK_BACK, '0);
    issue_request(MODE_POP_BACK, '0);
    issue_request(MODE_PUSH_FRONT, 32'shA5A5_A5A5);
    issue_request(MODE_POP_FRONT, '0);
    issue_request(MODE_CLEAR, '0);

    // Random phases, each at its own capacity. The first few hit the extremes,
    // including values above the built depth that act as the full depth.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: cap_value = 5'd16;
        1: cap_value = 5'd1;
        2: cap_value = 5'd31;
        3: cap_value = 5'd2;
        4: cap_value = 5'd17;
        default: cap_value = CNT_W'($urandom_range(0, 31));
      endcase
      write_capacity(cap_value);
      push_pct = $urandom_range(25, 80);
      gaps_on  = ($urandom_range(0, 3) != 0);
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = '0;
      value_pool[3] = '1;
      for (int i = 4; i < 8; i++) value_pool[i] = word_t'($urandom);
      for (int n = 0; n < WORDS_PER_PHASE; n++) random_request();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
src/cdq_pkg.sv
src/cdq_ring_step.sv
src/cdq_store.sv
src/circular_deque.sv
dv/circular_deque_checker.sv
dv/circular_deque_tb.sv
